// ===== src/hdu_pkg.sv =====
// Shared constants, types and lookup tables for the haversine distance unit.
package hdu_pkg;

	// Field widths
	localparam int LAT_W  = 24;
	localparam int LON_W  = 25;
	localparam int DIST_W = 18;
	localparam int ANG_W  = 27;   // signed degree value, holds any coordinate difference
	localparam int MAG_W  = 26;   // magnitude of a degree value

	// Datapath settings
	localparam int CORDIC_STAGES   = 24;
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int SQRT_STAGES     = 31;
	localparam int DW              = 34;
	localparam int ROOT_W          = 31;
	localparam int RAD_W           = 62;

	// Degree to binary angle: 2^32 / (360 * 2^F) = 2^(32-F-3) / 45
	localparam int DEG_DIV     = 45;
	localparam int SHIFT_FULL  = 32 - ANGLE_FRAC_BITS - 3;
	localparam int SHIFT_HALF  = SHIFT_FULL - 1;
	localparam int RND_DIV     = DEG_DIV / 2;
	localparam int RECIP_SHIFT = 31;
	localparam logic [MAG_W-1:0] RECIP_DIV = MAG_W'((64'd1 << RECIP_SHIFT) / DEG_DIV);
	localparam int QUOT_W      = 21;
	localparam int REM_W       = 6;

	// Fixed-point constants
	localparam logic signed [DW-1:0] CORDIC_KINV = DW'(652032874);
	localparam logic [ROOT_W-1:0] Q30_ONE = ROOT_W'(1) << 30;
	localparam logic [31:0] MILES16_PER_TURN = 32'd1630116033;
	localparam int DIST_RND_SHIFT = 43;
	localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(199216);

	typedef logic [31:0] bam_t;
	typedef logic signed [DW-1:0] cval_t;
	typedef logic [31:0] frac_tab_t [DEG_DIV];

	// Arctangent of 2^-i in binary-angle units
	localparam logic [31:0] ATAN_TAB [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
	};

	function automatic cval_t atan_step(input int i);
		return (i < 32) ? cval_t'(DW'(ATAN_TAB[i % 32])) : '0;
	endfunction

	// Rounded fraction of a turn for each remainder of the division by 45
	function automatic frac_tab_t make_frac_tab(input int sh);
		frac_tab_t t;
		for (int b = 0; b < DEG_DIV; b++) begin
			t[b] = 32'(((longint'(b) << sh) + RND_DIV) / DEG_DIV);
		end
		return t;
	endfunction

	localparam frac_tab_t TAB_FULL = make_frac_tab(SHIFT_FULL);
	localparam frac_tab_t TAB_HALF = make_frac_tab(SHIFT_HALF);

endpackage

// ===== src/haversine_distance_unit.sv =====
// Top level: haversine great-circle distance pipeline.
//
//  channel   ports                                           handshake
//  --------  ----------------------------------------------  -------------------
//  input     lat_a lon_a lat_b lon_b                         start && !busy
//  result    distance_miles                                  done, one cycle
//
//  One item enters per cycle; busy stays low since nothing in the pipeline waits.
//  The pipeline runs angle conversion, 24 sine/cosine CORDIC stages, the
//  haversine products, 31 square-root stages, 24 arctangent CORDIC stages
//  and scaling. Reset clears the valid bits only.
//  The receiver cannot stall: done pulses for one cycle per item.
module haversine_distance_unit import hdu_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [LAT_W-1:0] lat_a,
	input  logic signed [LON_W-1:0] lon_a,
	input  logic signed [LAT_W-1:0] lat_b,
	input  logic signed [LON_W-1:0] lon_b,
	output logic                    done,
	output logic [DIST_W-1:0]       distance_miles
);

	logic                    accept;
	logic signed [ANG_W-1:0] dlat, dlon, lat1, lat2;
	logic                    bam_v;
	bam_t                    bam_dlat, bam_dlon, bam_lat1, bam_lat2;
	logic                    rot_v;
	cval_t                   sin_dlat, sin_dlon, cos_lat1, cos_lat2;
	logic signed [2*DW-1:0]  sq_lat_full, sq_lon_full, cc_full, hp_full;
	logic                    v_s1, v_s2, v_s3, v_s4, v_s5;
	cval_t                   sq_lat_s1, sq_lon_s1, cc_s1;
	cval_t                   sq_lat_s2, prod_s2;
	logic signed [DW:0]      hav_sum;
	logic [ROOT_W-1:0]       a_s3;
	logic                    sqrt_v;
	logic [ROOT_W-1:0]       root_y, root_x;
	logic                    vec_v;
	cval_t                   vec_z;
	logic [ROOT_W-1:0]       z_clamp;
	logic [62:0]             prod_s4;
	logic [62:0]             dist_rnd;
	logic [19:0]             dist_full;
	logic [DIST_W-1:0]       dist_s5;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Coordinate differences, wrapping handled later modulo a turn
	assign lat1 = ANG_W'(lat_a);
	assign lat2 = ANG_W'(lat_b);
	assign dlat = ANG_W'(lat_b) - ANG_W'(lat_a);
	assign dlon = ANG_W'(lon_b) - ANG_W'(lon_a);

	hdu_bam u_bam_dlat (.clk, .arst_n, .in_valid(accept), .half(1'b1), .angle(dlat),
		.out_valid(bam_v), .bam(bam_dlat));
	hdu_bam u_bam_dlon (.clk, .arst_n, .in_valid(accept), .half(1'b1), .angle(dlon),
		.out_valid(), .bam(bam_dlon));
	hdu_bam u_bam_lat1 (.clk, .arst_n, .in_valid(accept), .half(1'b0), .angle(lat1),
		.out_valid(), .bam(bam_lat1));
	hdu_bam u_bam_lat2 (.clk, .arst_n, .in_valid(accept), .half(1'b0), .angle(lat2),
		.out_valid(), .bam(bam_lat2));

	hdu_rot u_rot_dlat (.clk, .arst_n, .in_valid(bam_v), .angle(bam_dlat),
		.out_valid(rot_v), .sine(sin_dlat), .cosine());
	hdu_rot u_rot_dlon (.clk, .arst_n, .in_valid(bam_v), .angle(bam_dlon),
		.out_valid(), .sine(sin_dlon), .cosine());
	hdu_rot u_rot_lat1 (.clk, .arst_n, .in_valid(bam_v), .angle(bam_lat1),
		.out_valid(), .sine(), .cosine(cos_lat1));
	hdu_rot u_rot_lat2 (.clk, .arst_n, .in_valid(bam_v), .angle(bam_lat2),
		.out_valid(), .sine(), .cosine(cos_lat2));

	// Haversine products
	assign sq_lat_full = sin_dlat * sin_dlat;
	assign sq_lon_full = sin_dlon * sin_dlon;
	assign cc_full     = cos_lat1 * cos_lat2;
	assign hp_full     = cc_s1 * sq_lon_s1;
	assign hav_sum     = (DW+1)'(sq_lat_s2) + (DW+1)'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= rot_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= vec_v;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		sq_lat_s1 <= DW'(sq_lat_full >>> 30);
		sq_lon_s1 <= DW'(sq_lon_full >>> 30);
		cc_s1     <= DW'(cc_full >>> 30);
		sq_lat_s2 <= sq_lat_s1;
		prod_s2   <= DW'(hp_full >>> 30);
		// Clamp the haversine term to [0, 1]
		if (hav_sum[DW]) begin
			a_s3 <= '0;
		end else if (hav_sum > (DW+1)'(Q30_ONE)) begin
			a_s3 <= Q30_ONE;
		end else begin
			a_s3 <= ROOT_W'(hav_sum);
		end
	end

	hdu_isqrt u_sqrt_a (.clk, .arst_n, .in_valid(v_s3),
		.radicand({1'b0, a_s3, 30'd0}), .out_valid(sqrt_v), .root(root_y));
	hdu_isqrt u_sqrt_b (.clk, .arst_n, .in_valid(v_s3),
		.radicand({1'b0, ROOT_W'(Q30_ONE - a_s3), 30'd0}), .out_valid(), .root(root_x));

	hdu_vec u_vec (.clk, .arst_n, .in_valid(sqrt_v), .x_in(root_x), .y_in(root_y),
		.out_valid(vec_v), .angle(vec_z));

	// Clamp the half central angle and scale to miles
	always_comb begin
		if (vec_z[DW-1]) begin
			z_clamp = '0;
		end else if (vec_z > cval_t'(DW'(Q30_ONE))) begin
			z_clamp = Q30_ONE;
		end else begin
			z_clamp = ROOT_W'(vec_z);
		end
	end

	assign dist_rnd  = prod_s4 + (63'(1) << (DIST_RND_SHIFT - 1));
	assign dist_full = 20'(dist_rnd >> DIST_RND_SHIFT);

	always_ff @(posedge clk) begin
		prod_s4 <= 63'(z_clamp) * 63'(MILES16_PER_TURN);
		dist_s5 <= (dist_full > 20'(DIST_MAX)) ? DIST_MAX : DIST_W'(dist_full);
	end

	assign done           = v_s5;
	assign distance_miles = dist_s5;

	a_dist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> distance_miles <= DIST_MAX)
		else $error("distance above bound");

	a_hav_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> a_s3 <= Q30_ONE)
		else $error("haversine term outside [0,1]");

	a_scale_flow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |=> done)
		else $error("scaled item lost before output");

endmodule

// ===== src/hdu_bam.sv =====
// Two-stage conversion of a degree value to a binary angle.
module hdu_bam import hdu_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    half,
	input  logic signed [ANG_W-1:0] angle,
	output logic                    out_valid,
	output bam_t                    bam
);

	logic [MAG_W-1:0]          mag;
	logic [2*MAG_W-1:0]        recip_prod;
	logic                      v_s1, neg_s1, half_s1;
	logic [MAG_W-1:0]          mag_s1;
	logic [QUOT_W-1:0]         quot_s1;
	logic [MAG_W-1:0]          rem_raw;
	logic                      fix;
	logic [QUOT_W-1:0]         quot;
	logic [REM_W-1:0]          rem;
	bam_t                      mag_bam;
	logic                      v_s2;
	bam_t                      bam_s2;

	// Estimate the quotient by 45 with a reciprocal
	assign mag        = angle[ANG_W-1] ? MAG_W'(-angle) : MAG_W'(angle);
	assign recip_prod = mag * RECIP_DIV;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1  <= angle[ANG_W-1];
		half_s1 <= half;
		mag_s1  <= mag;
		quot_s1 <= QUOT_W'(recip_prod >> RECIP_SHIFT);
	end

	// Correct the estimate by one, then add the rounded fraction from the table
	assign rem_raw = mag_s1 - MAG_W'(quot_s1 * DEG_DIV);
	assign fix     = rem_raw >= MAG_W'(DEG_DIV);
	assign quot    = quot_s1 + QUOT_W'(fix);
	assign rem     = fix ? REM_W'(rem_raw - MAG_W'(DEG_DIV)) : REM_W'(rem_raw);
	assign mag_bam = half_s1 ? (32'(quot) << SHIFT_HALF) + TAB_HALF[rem]
	                         : (32'(quot) << SHIFT_FULL) + TAB_FULL[rem];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		bam_s2 <= neg_s1 ? -mag_bam : mag_bam;
	end

	assign out_valid = v_s2;
	assign bam       = bam_s2;

endmodule

// ===== src/hdu_rot.sv =====
// Unrolled rotation-mode CORDIC giving sine and cosine of a binary angle.
module hdu_rot import hdu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  bam_t  angle,
	output logic  out_valid,
	output cval_t sine,
	output cval_t cosine
);

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;

	logic [1:0] quad0;
	bam_t       resid0;
	cval_t      x_s [1:CORDIC_STAGES];
	cval_t      y_s [1:CORDIC_STAGES];
	cval_t      z_s [1:CORDIC_STAGES];
	logic [1:0] q_s [1:CORDIC_STAGES];
	logic       v_s [1:CORDIC_STAGES];
	cval_t      xo, yo;

	// Split into a quadrant and a residual within half a quadrant
	assign quad0  = 2'(bam_t'(angle + 32'h2000_0000) >> 30);
	assign resid0 = angle - {quad0, 30'd0};

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		localparam cval_t STEP = atan_step(i);
		cval_t      xi, yi, zi;
		logic [1:0] qi;
		logic       vi;

		if (i == 0) begin : g_first
			assign xi = CORDIC_KINV;
			assign yi = '0;
			assign zi = DW'(signed'(resid0));
			assign qi = quad0;
			assign vi = in_valid;
		end else begin : g_next
			assign xi = x_s[i];
			assign yi = y_s[i];
			assign zi = z_s[i];
			assign qi = q_s[i];
			assign vi = v_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= vi;
			end
		end

		// Rotate toward zero residual
		always_ff @(posedge clk) begin
			q_s[i+1] <= qi;
			if (!zi[DW-1]) begin
				x_s[i+1] <= xi - (yi >>> i);
				y_s[i+1] <= yi + (xi >>> i);
				z_s[i+1] <= zi - STEP;
			end else begin
				x_s[i+1] <= xi + (yi >>> i);
				y_s[i+1] <= yi - (xi >>> i);
				z_s[i+1] <= zi + STEP;
			end
		end
	end

	assign xo = x_s[CORDIC_STAGES];
	assign yo = y_s[CORDIC_STAGES];

	// Map the result back to its quadrant
	always_comb begin
		case (q_s[CORDIC_STAGES])
			QUAD_I: begin
				cosine = xo;
				sine   = yo;
			end
			QUAD_II: begin
				cosine = -yo;
				sine   = xo;
			end
			QUAD_III: begin
				cosine = -xo;
				sine   = -yo;
			end
			default: begin
				cosine = yo;
				sine   = -xo;
			end
		endcase
	end

	assign out_valid = v_s[CORDIC_STAGES];

endmodule

// ===== src/hdu_isqrt.sv =====
// Pipelined floor square root, one result bit per stage.
module hdu_isqrt import hdu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [RAD_W-1:0]  radicand,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root
);

	logic [RAD_W-1:0] rem_s  [1:SQRT_STAGES];
	logic [RAD_W-1:0] root_s [1:SQRT_STAGES];
	logic             v_s    [1:SQRT_STAGES];

	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
		localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQRT_STAGES - 1 - i));
		logic [RAD_W-1:0] remi, rooti, trial;
		logic             vi;

		if (i == 0) begin : g_first
			assign remi  = radicand;
			assign rooti = '0;
			assign vi    = in_valid;
		end else begin : g_next
			assign remi  = rem_s[i];
			assign rooti = root_s[i];
			assign vi    = v_s[i];
		end

		assign trial = rooti + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= vi;
			end
		end

		// Subtract the trial value when it fits and set the bit
		always_ff @(posedge clk) begin
			if (remi >= trial) begin
				rem_s[i+1]  <= remi - trial;
				root_s[i+1] <= (rooti >> 1) + BIT;
			end else begin
				rem_s[i+1]  <= remi;
				root_s[i+1] <= rooti >> 1;
			end
		end
	end

	assign out_valid = v_s[SQRT_STAGES];
	assign root      = root_s[SQRT_STAGES][ROOT_W-1:0];

endmodule

// ===== src/hdu_vec.sv =====
// Unrolled vectoring-mode CORDIC giving the angle of a vector.
module hdu_vec import hdu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [ROOT_W-1:0] x_in,
	input  logic [ROOT_W-1:0] y_in,
	output logic              out_valid,
	output cval_t             angle
);

	cval_t x_s [1:CORDIC_STAGES];
	cval_t y_s [1:CORDIC_STAGES];
	cval_t z_s [1:CORDIC_STAGES];
	logic  v_s [1:CORDIC_STAGES];

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		localparam cval_t STEP = atan_step(i);
		cval_t xi, yi, zi;
		logic  vi;

		if (i == 0) begin : g_first
			assign xi = cval_t'(DW'(x_in));
			assign yi = cval_t'(DW'(y_in));
			assign zi = '0;
			assign vi = in_valid;
		end else begin : g_next
			assign xi = x_s[i];
			assign yi = y_s[i];
			assign zi = z_s[i];
			assign vi = v_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= vi;
			end
		end

		// Drive y toward zero and collect the angle
		always_ff @(posedge clk) begin
			if (!yi[DW-1]) begin
				x_s[i+1] <= xi + (yi >>> i);
				y_s[i+1] <= yi - (xi >>> i);
				z_s[i+1] <= zi + STEP;
			end else begin
				x_s[i+1] <= xi - (yi >>> i);
				y_s[i+1] <= yi + (xi >>> i);
				z_s[i+1] <= zi - STEP;
			end
		end
	end

	assign out_valid = v_s[CORDIC_STAGES];
	assign angle     = z_s[CORDIC_STAGES];

endmodule
